FILE: rtl/core/svd_pkg.sv
// ----------------------------------------------------------------------------
// svd_pkg: shared types for the vessel dynamics step
// Operand and accumulator widths and the micro-operation word that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package svd_pkg;

  localparam int MUL_W = 34;
  localparam int ACC_W = 72;
  localparam int SH_W  = 6;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    logic [SH_W-1:0]         sh;
    logic                    clr;
    logic                    neg;
  } op_t;

endpackage

FILE: rtl/core/svd_mac.sv
// ----------------------------------------------------------------------------
// svd_mac: shared multiply-accumulate unit
// One signed product per cycle, shifted left, optionally negated, added to
// or loaded into the accumulator.
// ----------------------------------------------------------------------------
module svd_mac
  import svd_pkg::*;
(
  input  logic                    clk,
  input  op_t                     op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;

  always_comb begin
    prod = op.a * op.b;
    term = $signed({{(ACC_W-2*MUL_W){prod[2*MUL_W-1]}}, prod}) <<< op.sh;
    if (op.neg) begin
      term = -term;
    end
    acc_nxt = (op.clr ? '0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: rtl/core/svd_cordic.sv
// ----------------------------------------------------------------------------
// svd_cordic: iterative sine and cosine
// Folds a binary angle into one half turn, then runs sixteen rotation steps,
// one per cycle. Outputs are Q4.30.
// ----------------------------------------------------------------------------
module svd_cordic
  import svd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [31:0]             angle,
  output logic signed [MUL_W-1:0] cos_o,
  output logic signed [MUL_W-1:0] sin_o,
  output logic                    done
);

  localparam logic signed [MUL_W-1:0] GAIN = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] QTR  = 34'sd1073741824;
  localparam logic signed [MUL_W-1:0] HALF = 34'sd2147483648;
  localparam logic [31:0] ATAN [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861
  };

  logic signed [MUL_W-1:0] x_r, y_r, z_r;
  logic signed [MUL_W-1:0] z0, dx, dy, at;
  logic                    neg_r, busy_r, done_r;
  logic [3:0]              idx_r;

  always_comb begin
    z0 = $signed({{2{angle[31]}}, angle});
    dx = y_r >>> idx_r;
    dy = x_r >>> idx_r;
    at = $signed({2'b00, ATAN[idx_r]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else if (start) begin
      x_r    <= GAIN;
      y_r    <= '0;
      idx_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
      if (z0 > QTR) begin
        z_r   <= z0 - HALF;
        neg_r <= 1'b1;
      end else if (z0 < -QTR) begin
        z_r   <= z0 + HALF;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z0;
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      idx_r <= idx_r + 4'd1;
      if (idx_r == 4'd15) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign cos_o = neg_r ? -x_r : x_r;
  assign sin_o = neg_r ? -y_r : y_r;
  assign done  = done_r;

endmodule

FILE: rtl/core/surface_vessel_dynamics_step.sv
// ----------------------------------------------------------------------------
// surface_vessel_dynamics_step: three-axis surface vessel Euler step
// One tick in, one updated state out, built around a shared multiply-
// accumulate unit and an iterative sine/cosine unit.
// Each input is taken from the idle state only, so a new one waits until the
// result is registered; a stalled output holds the finished result back.
// The 38-step multiply-accumulate program computes each tick; the sine/cosine
// unit runs alongside it. Reset (synchronous) zeroes state and start values.
// ----------------------------------------------------------------------------
module surface_vessel_dynamics_step
  import svd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_timestamp,
  input  logic signed [31:0] in_port_thrust,
  input  logic signed [31:0] in_starboard_thrust,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0] out_compass_heading,
  output logic [15:0] out_yaw_angle,
  output logic signed [31:0] out_surge_speed,
  output logic signed [31:0] out_sway_speed,
  output logic signed [31:0] out_yaw_rate
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [2:0] R_START_X   = 3'd0;
  localparam logic [2:0] R_START_Y   = 3'd1;
  localparam logic [2:0] R_START_HDG = 3'd2;
  localparam logic [2:0] R_START_U   = 3'd3;
  localparam logic [2:0] R_START_V   = 3'd4;
  localparam logic [2:0] R_START_R   = 3'd5;

  localparam logic [5:0] LAST_STEP = 6'd37;
  localparam logic [5:0] TRIG_STEP = 6'd23;

  localparam logic signed [MUL_W-1:0] K_ONE  = 34'sd1;
  localparam logic signed [MUL_W-1:0] K_240  = 34'sd240;
  localparam logic signed [MUL_W-1:0] K_75   = 34'sd75;
  localparam logic signed [MUL_W-1:0] K_190  = 34'sd190;
  localparam logic signed [MUL_W-1:0] K_105  = 34'sd105;
  localparam logic signed [MUL_W-1:0] K_50   = 34'sd50;
  localparam logic signed [MUL_W-1:0] K_55   = 34'sd55;
  localparam logic signed [MUL_W-1:0] INV11  = 34'sd88301;
  localparam logic signed [MUL_W-1:0] INV22  = 34'sd69905;
  localparam logic signed [MUL_W-1:0] INV33  = 34'sd204600;
  localparam logic signed [MUL_W-1:0] RAD_BA = 34'sd683565276;

  localparam logic signed [ACC_W-1:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -72'sd2147483648;
  localparam logic signed [ACC_W-1:0] C34_MAX = 72'sd8589934591;
  localparam logic signed [ACC_W-1:0] C34_MIN = -72'sd8589934592;
  localparam logic signed [ACC_W-1:0] UV_MAX  = 72'sd68719476736;
  localparam logic signed [ACC_W-1:0] UV_MIN  = -72'sd68719476736;
  localparam logic signed [ACC_W-1:0] NUM_MAX = 72'sd549755813888;
  localparam logic signed [ACC_W-1:0] NUM_MIN = -72'sd549755813888;

  localparam logic [SH_W-1:0] SH0  = 6'd0;
  localparam logic [SH_W-1:0] SH16 = 6'd16;
  localparam logic [SH_W-1:0] SH17 = 6'd17;
  localparam logic [SH_W-1:0] SH20 = 6'd20;
  localparam logic [SH_W-1:0] SH32 = 6'd32;

  function automatic logic signed [ACC_W-1:0] clamp(input logic signed [ACC_W-1:0] v,
                                                    input logic signed [ACC_W-1:0] hi,
                                                    input logic signed [ACC_W-1:0] lo);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = clamp(v, S32_MAX, S32_MIN);
    return c[31:0];
  endfunction

  function automatic logic signed [MUL_W-1:0] sx(input logic [31:0] v);
    return $signed({{(MUL_W-32){v[31]}}, v});
  endfunction

  function automatic logic signed [MUL_W-1:0] zx(input logic [31:0] v);
    return $signed({{(MUL_W-32){1'b0}}, v});
  endfunction

  function automatic op_t mk(input logic signed [MUL_W-1:0] a,
                             input logic signed [MUL_W-1:0] b,
                             input logic [SH_W-1:0] sh, input logic clr, input logic neg);
    op_t o;
    o.a   = a;
    o.b   = b;
    o.sh  = sh;
    o.clr = clr;
    o.neg = neg;
    return o;
  endfunction

  state_t state_r;
  logic [5:0] step_r;

  logic [31:0] start_x_r, start_y_r;
  logic [31:0] east_r, north_r, heading_r, surge_r, sway_r, rate_r, last_time_r;
  logic        started_r;

  logic [31:0] dt_r, p_r, sb_r;
  logic [37:0] uv_r;
  logic [33:0] ur_r, vr_r;
  logic [40:0] num_r;
  logic [31:0] du_r, dv_r, dr_r, dx_r, dy_r;
  logic [31:0] w_r;

  logic        out_valid_r;
  logic [31:0] o_x_r, o_y_r, o_u_r, o_v_r, o_r_r;
  logic [15:0] o_cmp_r, o_yaw_r;

  op_t                     op;
  logic signed [ACC_W-1:0] acc, acc_s16, acc_s24, acc_s30;
  logic signed [ACC_W-1:0] cl_uv, cl_34, cl_num;
  logic signed [31:0]      sat16, sat24, sat30;
  logic signed [MUL_W-1:0] cos_v, sin_v, nh, nl, uh, ul, wl, wh, dtm;
  logic                    cor_done, accept;
  logic [31:0]             cmp_full;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  svd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .angle (heading_r),
    .cos_o (cos_v),
    .sin_o (sin_v),
    .done  (cor_done)
  );

  svd_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  always_comb begin
    acc_s16 = acc >>> 16;
    acc_s24 = acc >>> 24;
    acc_s30 = acc >>> 30;
    cl_uv   = clamp(acc_s16, UV_MAX, UV_MIN);
    cl_34   = clamp(acc_s16, C34_MAX, C34_MIN);
    cl_num  = clamp(acc, NUM_MAX, NUM_MIN);
    sat16   = sat32(acc_s16);
    sat24   = sat32(acc_s24);
    sat30   = sat32(acc_s30);
    nh      = $signed({{(MUL_W-21){cl_num[40]}}, cl_num[40:20]});
    nl      = $signed({{(MUL_W-20){1'b0}}, num_r[19:0]});
    uh      = $signed({{(MUL_W-21){uv_r[37]}}, uv_r[37:17]});
    ul      = $signed({{(MUL_W-17){1'b0}}, uv_r[16:0]});
    wl      = zx(acc[31:0]);
    wh      = sx(w_r);
    dtm     = zx(dt_r);
    cmp_full = 32'h4000_0000 - heading_r;
  end

  always_comb begin
    unique case (step_r)
      6'd0:  op = mk(sx(surge_r), sx(sway_r), SH0, 1'b1, 1'b0);
      6'd1:  op = mk(sx(surge_r), sx(rate_r), SH0, 1'b1, 1'b0);
      6'd2:  op = mk(sx(sway_r), sx(rate_r), SH0, 1'b1, 1'b0);
      6'd3:  op = mk(sx(p_r), K_ONE, SH0, 1'b1, 1'b0);
      6'd4:  op = mk(sx(sb_r), K_ONE, SH0, 1'b0, 1'b0);
      6'd5:  op = mk($signed(vr_r), K_240, SH0, 1'b0, 1'b0);
      6'd6:  op = mk(sx(surge_r), K_75, SH0, 1'b0, 1'b1);
      6'd7:  op = mk(nh, INV11, SH20, 1'b1, 1'b0);
      6'd8:  op = mk(nl, INV11, SH0, 1'b0, 1'b0);
      6'd9:  op = mk($signed(ur_r), K_190, SH0, 1'b1, 1'b1);
      6'd10: op = mk(sx(sway_r), K_105, SH0, 1'b0, 1'b1);
      6'd11: op = mk(nh, INV22, SH20, 1'b1, 1'b0);
      6'd12: op = mk(nl, INV22, SH0, 1'b0, 1'b0);
      6'd13: op = mk(sx(sb_r), K_ONE, SH0, 1'b1, 1'b0);
      6'd14: op = mk(sx(p_r), K_ONE, SH0, 1'b0, 1'b1);
      6'd15: op = mk(uh, K_50, SH17, 1'b0, 1'b1);
      6'd16: op = mk(ul, K_50, SH0, 1'b0, 1'b1);
      6'd17: op = mk(sx(rate_r), K_55, SH0, 1'b0, 1'b1);
      6'd18: op = mk(nh, INV33, SH20, 1'b1, 1'b0);
      6'd19: op = mk(nl, INV33, SH0, 1'b0, 1'b0);
      6'd20: op = mk(sx(rate_r), RAD_BA, SH0, 1'b1, 1'b0);
      6'd21: op = mk(dtm, wl, SH0, 1'b1, 1'b0);
      6'd22: op = mk(dtm, wh, SH32, 1'b0, 1'b0);
      6'd23: op = mk(sx(surge_r), cos_v, SH0, 1'b1, 1'b0);
      6'd24: op = mk(sx(sway_r), sin_v, SH0, 1'b0, 1'b1);
      6'd25: op = mk(sx(surge_r), sin_v, SH0, 1'b1, 1'b0);
      6'd26: op = mk(sx(sway_r), cos_v, SH0, 1'b0, 1'b0);
      6'd27: op = mk(sx(east_r), K_ONE, SH16, 1'b1, 1'b0);
      6'd28: op = mk(dtm, sx(dx_r), SH0, 1'b0, 1'b0);
      6'd29: op = mk(sx(north_r), K_ONE, SH16, 1'b1, 1'b0);
      6'd30: op = mk(dtm, sx(dy_r), SH0, 1'b0, 1'b0);
      6'd31: op = mk(sx(surge_r), K_ONE, SH16, 1'b1, 1'b0);
      6'd32: op = mk(dtm, sx(du_r), SH0, 1'b0, 1'b0);
      6'd33: op = mk(sx(sway_r), K_ONE, SH16, 1'b1, 1'b0);
      6'd34: op = mk(dtm, sx(dv_r), SH0, 1'b0, 1'b0);
      6'd35: op = mk(sx(rate_r), K_ONE, SH16, 1'b1, 1'b0);
      6'd36: op = mk(dtm, sx(dr_r), SH0, 1'b0, 1'b0);
      default: op = mk('0, '0, SH0, 1'b1, 1'b0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      east_r       <= '0;
      north_r      <= '0;
      heading_r    <= '0;
      surge_r      <= '0;
      sway_r       <= '0;
      rate_r       <= '0;
      last_time_r  <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          R_START_X:   start_x_r <= cfg_data;
          R_START_Y:   start_y_r <= cfg_data;
          R_START_HDG: begin
            if (!started_r) heading_r <= cfg_data;
          end
          R_START_U: begin
            if (!started_r) surge_r <= cfg_data;
          end
          R_START_V: begin
            if (!started_r) sway_r <= cfg_data;
          end
          R_START_R: begin
            if (!started_r) rate_r <= cfg_data;
          end
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            dt_r        <= in_timestamp - last_time_r;
            last_time_r <= in_timestamp;
            p_r         <= in_port_thrust;
            sb_r        <= in_starboard_thrust;
            if (!started_r) begin
              east_r    <= start_x_r;
              north_r   <= start_y_r;
              started_r <= 1'b1;
            end
            step_r  <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          unique case (step_r)
            6'd1:  uv_r      <= cl_uv[37:0];
            6'd2:  ur_r      <= cl_34[33:0];
            6'd3:  vr_r      <= cl_34[33:0];
            6'd7:  num_r     <= cl_num[40:0];
            6'd9:  du_r      <= sat24;
            6'd11: num_r     <= cl_num[40:0];
            6'd13: dv_r      <= sat24;
            6'd18: num_r     <= cl_num[40:0];
            6'd20: dr_r      <= sat24;
            6'd21: w_r       <= acc[63:32];
            6'd23: heading_r <= heading_r + acc[63:32];
            6'd25: dx_r      <= sat30;
            6'd27: dy_r      <= sat30;
            6'd29: east_r    <= sat16;
            6'd31: north_r   <= sat16;
            6'd33: surge_r   <= sat16;
            6'd35: sway_r    <= sat16;
            6'd37: rate_r    <= sat16;
            default: ;
          endcase
          if (step_r == LAST_STEP) begin
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            o_x_r       <= east_r;
            o_y_r       <= north_r;
            o_cmp_r     <= cmp_full[31:16];
            o_yaw_r     <= heading_r[31:16];
            o_u_r       <= surge_r;
            o_v_r       <= sway_r;
            o_r_r       <= rate_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pos_x           = o_x_r;
  assign out_pos_y           = o_y_r;
  assign out_compass_heading = o_cmp_r;
  assign out_yaw_angle       = o_yaw_r;
  assign out_surge_speed     = o_u_r;
  assign out_sway_speed      = o_v_r;
  assign out_yaw_rate        = o_r_r;

`ifndef NO_ASSERTIONS
  a_trig_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && step_r == TRIG_STEP) |-> cor_done)
    else $error("sine/cosine not ready when first used");

  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RUN && step_r == '0))
    else $error("accepted transaction did not start the program");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("finished result not presented");
`endif

endmodule
